// ===== hw/rtl/periodic_task_rm_edf_scheduler_defines.svh =====
// assertion macros shared by the scheduler rtl
// depends on nothing; included by files that carry assertions
`ifndef PERIODIC_TASK_RM_EDF_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_RM_EDF_SCHEDULER_DEFINES_SVH
`ifndef SYNTH
`define PTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("scheduler assertion failed");
`define PTS_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("scheduler forbidden condition");
`else
`define PTS_ASSERT(lbl, clk, rstn, prop)
`define PTS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== hw/rtl/ptsched_pkg.sv =====
// types and constants of the periodic task scheduler
// depends on nothing
`timescale 1ns / 1ps
package ptsched_pkg;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [15:0] MAX16 = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_RET,
    ST_ACC,
    ST_REL,
    ST_SEL,
    ST_PICK,
    ST_WAIT,
    ST_FIN
  } state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    state_e state;
    logic   cnt_inc;
    logic   cnt_clr;
  } seq_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  task_index;
    logic [15:0] release_time;
    logic [15:0] job_duration;
    logic [15:0] task_period;
    logic [15:0] rel_deadline;
  } req_t;

  typedef struct packed {
    logic [31:0] now_time;
    logic [2:0]  running_task;
    logic        cpu_idle;
    logic        switched;
    logic [7:0]  missed_mask;
    logic [7:0]  released_mask;
    logic [31:0] switch_total;
    logic [15:0] stat_lost;
    logic [31:0] stat_turnaround;
    logic [31:0] stat_wait;
    logic [15:0] stat_instances;
  } res_t;

endpackage

// ===== hw/rtl/ptsched_alu.sv =====
// shared 32 bit add / subtract unit with saturating add result
// depends on ptsched_pkg
`timescale 1ns / 1ps
module ptsched_alu (
  input  logic [31:0]          a_i,
  input  logic [31:0]          b_i,
  input  ptsched_pkg::alu_op_e op_i,
  output logic [32:0]          raw_o,
  output logic [31:0]          sat_o
);
  import ptsched_pkg::*;

  // raw sum or difference
  always_comb begin
    if (op_i == ALU_SUB) begin
      raw_o = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      raw_o = {1'b0, a_i} + {1'b0, b_i};
    end
  end

  // clamp carry out on add
  assign sat_o = (op_i == ALU_ADD && raw_o[32]) ? MAX32 : raw_o[31:0];

endmodule

// ===== hw/rtl/ptsched_ctrl.sv =====
// sequencer of the scheduler: request decode and slot scan phases
// depends on ptsched_pkg
`timescale 1ns / 1ps
module ptsched_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        req_type_i,
  input  logic              last_i,
  output ptsched_pkg::seq_t seq_o
);
  import ptsched_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_type_i == REQ_TICK) state_d = ST_RET;
          else if (req_type_i == REQ_READ) state_d = ST_READ;
          else state_d = ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_IDLE;
      ST_READ: state_d = ST_IDLE;
      ST_RET:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_REL;
      ST_REL:  state_d = last_i ? ST_SEL : ST_RET;
      ST_SEL:  state_d = last_i ? ST_PICK : ST_SEL;
      ST_PICK: state_d = ST_WAIT;
      ST_WAIT: state_d = last_i ? ST_FIN : ST_WAIT;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // slot counter control
  always_comb begin
    seq_o.state   = state_q;
    seq_o.cnt_inc = 1'b0;
    seq_o.cnt_clr = 1'b0;
    unique case (state_q)
      ST_REL, ST_SEL, ST_WAIT: begin
        seq_o.cnt_inc = !last_i;
        seq_o.cnt_clr = last_i;
      end
      default: begin
        seq_o.cnt_inc = 1'b0;
        seq_o.cnt_clr = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/periodic_task_rm_edf_scheduler.sv =====
// load and read pass through ST_LOAD or ST_READ and then the result register.
// a tick runs per-slot scans through the shared adder: retire (ST_RET, ST_ACC) and
// release (ST_REL) per slot, then select (ST_SEL), ST_PICK, the wait scan (ST_WAIT)
// and ST_FIN. a new request is taken only while idle, busy_o high meanwhile.
// reset: asynchronous active low, clears time, tasks, jobs and statistics.
// results appear for one cycle on done_o; the receiver cannot stall.
`timescale 1ns / 1ps
`include "periodic_task_rm_edf_scheduler_defines.svh"
module periodic_task_rm_edf_scheduler #(
  parameter int MAX_TASKS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  ptsched_pkg::req_t req_i,
  output logic              done_o,
  output ptsched_pkg::res_t res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);
  import ptsched_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  seq_t seq;
  logic accept, last;
  logic [IW-1:0] cnt_q;
  logic [31:0] cnt_ext;
  req_t req_q;
  logic slot_ok;

  logic mode_q;
  logic [31:0] cur_q, switch_q;
  logic run_valid_q;
  logic [IW-1:0] run_slot_q;

  logic          valid_q    [MAX_TASKS];
  logic          active_q   [MAX_TASKS];
  logic [15:0]   dur_q      [MAX_TASKS];
  logic [15:0]   per_q      [MAX_TASKS];
  logic [15:0]   dl_q       [MAX_TASKS];
  logic [31:0]   nrel_q     [MAX_TASKS];
  logic [31:0]   jrel_q     [MAX_TASKS];
  logic [15:0]   exec_q     [MAX_TASKS];
  logic [15:0]   lost_q     [MAX_TASKS];
  logic [31:0]   turn_q     [MAX_TASKS];
  logic [31:0]   wait_q     [MAX_TASKS];
  logic [15:0]   inst_q     [MAX_TASKS];

  logic retire_q, miss_q, rel_q;
  logic [31:0] diff_q;
  logic found_q;
  logic [IW-1:0] best_q;
  logic [32:0] best_key_q;
  logic [7:0] missed_q, released_q;
  logic switched_q;

  logic [31:0] alu_a, alu_b, alu_sat;
  logic [32:0] alu_raw;
  alu_op_e alu_op;
  logic [32:0] key;
  logic [15:0] ld_per, ld_dl;
  logic [31:0] best_ext;

  logic done_q;
  res_t res_q, res_d;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (seq.state != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign last        = (cnt_q == IW'(MAX_TASKS - 1));
  assign cnt_ext     = 32'(cnt_q);
  assign best_ext    = 32'(best_q);
  assign slot_ok     = (32'(req_q.task_index) < 32'(MAX_TASKS));
  assign done_o      = done_q;
  assign res_o       = res_q;

  // sequencer
  ptsched_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .req_type_i (req_i.req_type),
    .last_i     (last),
    .seq_o      (seq)
  );

  // shared adder operand selection
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_ADD;
    case (seq.state)
      ST_RET: begin
        alu_a  = cur_q;
        alu_b  = jrel_q[cnt_q];
        alu_op = ALU_SUB;
      end
      ST_ACC: begin
        alu_a = turn_q[cnt_q];
        alu_b = diff_q;
      end
      ST_REL: begin
        alu_a = nrel_q[cnt_q];
        alu_b = {16'd0, per_q[cnt_q]};
      end
      ST_SEL: begin
        alu_a = jrel_q[cnt_q];
        alu_b = {16'd0, dl_q[cnt_q]};
      end
      ST_WAIT: begin
        alu_a = wait_q[cnt_q];
        alu_b = 32'd1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  ptsched_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .raw_o (alu_raw),
    .sat_o (alu_sat)
  );

  // selection key of the scanned slot
  assign key = mode_q ? alu_raw : {17'd0, per_q[cnt_q]};

  // load value clamping
  always_comb begin
    ld_per = (req_q.task_period == 16'd0) ? 16'd1 : req_q.task_period;
    ld_dl  = (req_q.rel_deadline > ld_per) ? ld_per : req_q.rel_deadline;
  end

  // request capture, counter and mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mode_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) mode_q <= cfg_data_i;
      if (accept) begin
        cnt_q <= (req_i.req_type == REQ_TICK) ? '0 : IW'(req_i.task_index);
      end else if (seq.cnt_clr) begin
        cnt_q <= '0;
      end else if (seq.cnt_inc) begin
        cnt_q <= cnt_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
  end

  // per-slot scan flags and task parameters
  always_ff @(posedge clk_i) begin
    case (seq.state)
      ST_LOAD: begin
        if (slot_ok && req_q.req_type == REQ_LOAD) begin
          dur_q[cnt_q]  <= req_q.job_duration;
          per_q[cnt_q]  <= ld_per;
          dl_q[cnt_q]   <= ld_dl;
          nrel_q[cnt_q] <= {16'd0, req_q.release_time};
        end
      end
      ST_RET: begin
        diff_q   <= alu_raw[31:0];
        retire_q <= active_q[cnt_q] && ((exec_q[cnt_q] >= dur_q[cnt_q])
                    || (alu_raw[31:0] >= {16'd0, dl_q[cnt_q]}));
        miss_q   <= active_q[cnt_q] && (exec_q[cnt_q] < dur_q[cnt_q])
                    && (alu_raw[31:0] >= {16'd0, dl_q[cnt_q]});
      end
      ST_ACC: begin
        rel_q <= valid_q[cnt_q] && !(active_q[cnt_q] && !retire_q)
                 && (cur_q >= nrel_q[cnt_q]);
        if (valid_q[cnt_q] && !(active_q[cnt_q] && !retire_q)
            && (cur_q >= nrel_q[cnt_q])) begin
          jrel_q[cnt_q] <= nrel_q[cnt_q];
          exec_q[cnt_q] <= 16'd0;
        end
      end
      ST_REL: begin
        if (rel_q) nrel_q[cnt_q] <= alu_sat;
      end
      ST_SEL: begin
        if (active_q[cnt_q] && (!found_q || key < best_key_q)) begin
          best_q     <= cnt_q;
          best_key_q <= key;
        end
      end
      ST_WAIT: begin
        if (active_q[cnt_q] && found_q && cnt_q == best_q
            && exec_q[cnt_q] != MAX16) begin
          exec_q[cnt_q] <= exec_q[cnt_q] + 16'd1;
        end
      end
      default: begin
        diff_q <= diff_q;
      end
    endcase
  end

  // scheduler control state and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      switch_q    <= '0;
      run_valid_q <= 1'b0;
      run_slot_q  <= '0;
      found_q     <= 1'b0;
      missed_q    <= '0;
      released_q  <= '0;
      switched_q  <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        valid_q[i]  <= 1'b0;
        active_q[i] <= 1'b0;
        lost_q[i]   <= '0;
        turn_q[i]   <= '0;
        wait_q[i]   <= '0;
        inst_q[i]   <= '0;
      end
    end else begin
      if (accept) begin
        found_q    <= 1'b0;
        missed_q   <= '0;
        released_q <= '0;
        switched_q <= 1'b0;
      end
      case (seq.state)
        ST_LOAD: begin
          if (slot_ok && req_q.req_type == REQ_LOAD) begin
            valid_q[cnt_q]  <= 1'b1;
            active_q[cnt_q] <= 1'b0;
            if (run_valid_q && run_slot_q == cnt_q) run_valid_q <= 1'b0;
          end
        end
        ST_ACC: begin
          // retire the finished or late job
          if (retire_q) begin
            turn_q[cnt_q] <= alu_sat;
            if (inst_q[cnt_q] != MAX16) inst_q[cnt_q] <= inst_q[cnt_q] + 16'd1;
            if (miss_q) begin
              if (lost_q[cnt_q] != MAX16) lost_q[cnt_q] <= lost_q[cnt_q] + 16'd1;
              if (cnt_ext < 32'd8) missed_q[cnt_ext[2:0]] <= 1'b1;
            end
            if (run_valid_q && run_slot_q == cnt_q) run_valid_q <= 1'b0;
          end
          // release a due job
          if (valid_q[cnt_q] && !(active_q[cnt_q] && !retire_q)
              && (cur_q >= nrel_q[cnt_q])) begin
            active_q[cnt_q] <= 1'b1;
            if (cnt_ext < 32'd8) released_q[cnt_ext[2:0]] <= 1'b1;
          end else if (retire_q) begin
            active_q[cnt_q] <= 1'b0;
          end
        end
        ST_SEL: begin
          if (active_q[cnt_q]) found_q <= 1'b1;
        end
        ST_PICK: begin
          if (found_q && !(run_valid_q && run_slot_q == best_q)) begin
            run_valid_q <= 1'b1;
            run_slot_q  <= best_q;
            switched_q  <= 1'b1;
            if (switch_q != MAX32) switch_q <= switch_q + 32'd1;
          end
          if (!found_q) run_valid_q <= 1'b0;
        end
        ST_WAIT: begin
          if (active_q[cnt_q] && !(found_q && cnt_q == best_q)) begin
            wait_q[cnt_q] <= alu_sat;
          end
        end
        ST_FIN: begin
          if (cur_q != MAX32) cur_q <= cur_q + 32'd1;
        end
        default: begin
          cur_q <= cur_q;
        end
      endcase
    end
  end

  // result register and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (seq.state == ST_LOAD) || (seq.state == ST_READ)
                || (seq.state == ST_FIN);
    end
  end

  // result assembly
  always_comb begin
    res_d              = '0;
    res_d.now_time     = cur_q;
    res_d.switch_total = switch_q;
    if (seq.state == ST_READ && slot_ok && req_q.req_type == REQ_READ) begin
      res_d.stat_lost       = lost_q[cnt_q];
      res_d.stat_turnaround = turn_q[cnt_q];
      res_d.stat_wait       = wait_q[cnt_q];
      res_d.stat_instances  = inst_q[cnt_q];
    end
    if (seq.state == ST_FIN) begin
      res_d.running_task  = found_q ? best_ext[2:0] : 3'd0;
      res_d.cpu_idle      = !found_q;
      res_d.switched      = switched_q;
      res_d.missed_mask   = missed_q;
      res_d.released_mask = released_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq.state == ST_LOAD || seq.state == ST_READ || seq.state == ST_FIN) begin
      res_q <= res_d;
    end
  end

  // checks
  `PTS_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy_o)
  `PTS_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> busy_o)
  `PTS_NEVER(a_idle_no_switch, clk_i, rst_ni, done_o && res_o.cpu_idle && res_o.switched)

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench of the periodic task scheduler, rm and edf modes
// depends on ptsched_pkg and periodic_task_rm_edf_scheduler
`timescale 1ns / 1ps
module tb_top;
  import ptsched_pkg::*;

  localparam int NSLOT    = 8;
  localparam int TICK_LAT = 5 * NSLOT + 3;
  localparam int LIMIT    = 400000;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  req_t req_i = '0;
  logic done_o;
  res_t res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;

  periodic_task_rm_edf_scheduler #(.MAX_TASKS(NSLOT)) i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .done_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // scheduler state mirrored by the predictor
  logic        edf_mode;
  logic [31:0] now_ticks;
  logic        slot_valid [NSLOT];
  logic [15:0] slot_dur [NSLOT];
  logic [15:0] slot_per [NSLOT];
  logic [15:0] slot_dl [NSLOT];
  logic [31:0] slot_next [NSLOT];
  logic        job_on [NSLOT];
  logic [31:0] job_rel [NSLOT];
  logic [15:0] job_ran [NSLOT];
  logic        run_valid;
  int          run_slot;
  logic [15:0] lost_cnt [NSLOT];
  logic [31:0] turn_sum [NSLOT];
  logic [31:0] wait_acc [NSLOT];
  logic [15:0] inst_cnt [NSLOT];
  logic [31:0] switch_cnt;

  req_t pending_reqs[$];
  res_t expected_res[$];
  int   errors = 0;
  int   cycles = 0;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [32:0] b);
    logic [33:0] s;
    s = {2'b0, a} + {1'b0, b};
    return (s > 34'hFFFF_FFFF) ? MAX32 : s[31:0];
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] a);
    return (a == MAX16) ? a : a + 16'd1;
  endfunction

  // works out the result of one request and advances the mirrored state
  function automatic res_t sched_step(req_t r);
    res_t        o;
    logic [7:0]  miss;
    logic [7:0]  rel;
    logic        found;
    logic        sw;
    int          best;
    logic [32:0] key;
    logic [32:0] best_key;
    logic        done;
    logic        late;
    logic [15:0] per;
    logic [15:0] dl;
    o = '0;
    o.now_time = now_ticks;
    miss = '0; rel = '0; found = 1'b0; sw = 1'b0; best = 0; best_key = '0;
    if (r.req_type == REQ_TICK) begin
      // retire finished or late jobs
      for (int i = 0; i < NSLOT; i++) begin
        if (job_on[i]) begin
          done = job_ran[i] >= slot_dur[i];
          late = {1'b0, now_ticks} >= {1'b0, job_rel[i]} + slot_dl[i];
          if (!done && late) begin
            lost_cnt[i] = sat_inc(lost_cnt[i]);
            miss[i] = 1'b1;
          end
          if (done || late) begin
            turn_sum[i] = sat_add(turn_sum[i], {1'b0, now_ticks - job_rel[i]});
            inst_cnt[i] = sat_inc(inst_cnt[i]);
            job_on[i] = 1'b0;
            if (run_valid && run_slot == i) run_valid = 1'b0;
          end
        end
      end
      // release due jobs
      for (int i = 0; i < NSLOT; i++) begin
        if (slot_valid[i] && !job_on[i] && now_ticks >= slot_next[i]) begin
          job_on[i] = 1'b1;
          job_rel[i] = slot_next[i];
          job_ran[i] = '0;
          slot_next[i] = sat_add(slot_next[i], {17'b0, slot_per[i]});
          rel[i] = 1'b1;
        end
      end
      // pick the running job, lowest index on ties
      for (int i = 0; i < NSLOT; i++) begin
        if (job_on[i]) begin
          key = edf_mode ? {1'b0, job_rel[i]} + slot_dl[i] : {17'b0, slot_per[i]};
          if (!found || key < best_key) begin
            found = 1'b1;
            best = i;
            best_key = key;
          end
        end
      end
      if (found && !(run_valid && run_slot == best)) begin
        run_valid = 1'b1;
        run_slot = best;
        if (switch_cnt != MAX32) switch_cnt++;
        sw = 1'b1;
      end
      if (!found) run_valid = 1'b0;
      // ready but not running
      for (int i = 0; i < NSLOT; i++)
        if (job_on[i] && !(found && i == best)) wait_acc[i] = sat_add(wait_acc[i], 33'd1);
      o.running_task = found ? best[2:0] : 3'd0;
      o.cpu_idle = !found;
      o.switched = sw;
      o.missed_mask = miss;
      o.released_mask = rel;
      if (found) job_ran[best] = sat_inc(job_ran[best]);
      if (now_ticks != MAX32) now_ticks++;
    end else if (r.req_type == REQ_LOAD) begin
      per = (r.task_period == 16'd0) ? 16'd1 : r.task_period;
      dl = (r.rel_deadline > per) ? per : r.rel_deadline;
      slot_valid[r.task_index] = 1'b1;
      slot_next[r.task_index] = {16'b0, r.release_time};
      slot_dur[r.task_index] = r.job_duration;
      slot_per[r.task_index] = per;
      slot_dl[r.task_index] = dl;
      job_on[r.task_index] = 1'b0;
      if (run_valid && run_slot == r.task_index) run_valid = 1'b0;
    end else if (r.req_type == REQ_READ) begin
      o.stat_lost = lost_cnt[r.task_index];
      o.stat_turnaround = turn_sum[r.task_index];
      o.stat_wait = wait_acc[r.task_index];
      o.stat_instances = inst_cnt[r.task_index];
    end
    o.switch_total = switch_cnt;
    return o;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", field, got, want);
    errors++;
  endtask

  // driver: one request per draw, random gap after each (no gap during calm runs)
  int gap = 0;
  int calm = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      gap <= 0;
    end else if (start_i && busy_o) begin
      // holding the request until the block takes it
    end else if (start_i) begin
      expected_res.insert(expected_res.size(), sched_step(req_i));
      if (calm > 0) begin
        calm <= calm - 1;
        gap <= 0;
      end else begin
        gap <= $urandom_range(0, 7);
        if ($urandom_range(0, 15) == 0) calm <= $urandom_range(10, 30);
      end
      start_i <= 1'b0;
    end else if (gap > 0) begin
      gap <= gap - 1;
    end else if (pending_reqs.size() > 0) begin
      req_i <= pending_reqs.pop_front();
      start_i <= 1'b1;
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      if (expected_res.size() == 0) begin
        $display("unexpected result at now_time %0h", res_o.now_time);
        errors++;
      end else begin
        want = expected_res.pop_front();
        if (res_o.now_time !== want.now_time) report("now_time", res_o.now_time, want.now_time);
        if (res_o.running_task !== want.running_task)
          report("running_task", res_o.running_task, want.running_task);
        if (res_o.cpu_idle !== want.cpu_idle) report("cpu_idle", res_o.cpu_idle, want.cpu_idle);
        if (res_o.switched !== want.switched) report("switched", res_o.switched, want.switched);
        if (res_o.missed_mask !== want.missed_mask)
          report("missed_mask", res_o.missed_mask, want.missed_mask);
        if (res_o.released_mask !== want.released_mask)
          report("released_mask", res_o.released_mask, want.released_mask);
        if (res_o.switch_total !== want.switch_total)
          report("switch_total", res_o.switch_total, want.switch_total);
        if (res_o.stat_lost !== want.stat_lost) report("stat_lost", res_o.stat_lost, want.stat_lost);
        if (res_o.stat_turnaround !== want.stat_turnaround)
          report("stat_turnaround", res_o.stat_turnaround, want.stat_turnaround);
        if (res_o.stat_wait !== want.stat_wait) report("stat_wait", res_o.stat_wait, want.stat_wait);
        if (res_o.stat_instances !== want.stat_instances)
          report("stat_instances", res_o.stat_instances, want.stat_instances);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic req_t mk_req(logic [1:0] t, logic [2:0] idx, logic [15:0] rt,
                                  logic [15:0] dur, logic [15:0] per, logic [15:0] dl);
    req_t r;
    r.req_type = t; r.task_index = idx; r.release_time = rt;
    r.job_duration = dur; r.task_period = per; r.rel_deadline = dl;
    return r;
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [2:0] rnd_slot();
    return 3'($urandom_range(0, 7));
  endfunction

  // random request, mostly well-formed small task sets
  function automatic req_t rnd_req();
    int          pick;
    logic [15:0] per;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return mk_req(REQ_TICK, rnd_slot(), rnd16(), rnd16(), rnd16(), rnd16());
    if (pick < 75) begin
      if ($urandom_range(0, 7) == 0)
        return mk_req(REQ_LOAD, rnd_slot(), rnd16(), rnd16(), rnd16(), rnd16());
      per = 16'($urandom_range(1, 24));
      return mk_req(REQ_LOAD, rnd_slot(), 16'($urandom_range(0, 40)),
                    16'($urandom_range(0, per)), per, 16'($urandom_range(1, per)));
    end
    if (pick < 95)
      return mk_req(REQ_READ, rnd_slot(), rnd16(), rnd16(), rnd16(), rnd16());
    return mk_req(REQ_SPARE, rnd_slot(), rnd16(), rnd16(), rnd16(), rnd16());
  endfunction

  task automatic add_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic drain();
    while (!(pending_reqs.size() == 0 && !start_i && expected_res.size() == 0))
      @(posedge clk_i);
    repeat (TICK_LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    edf_mode = m;
  endtask

  initial begin
    edf_mode = 1'b0; now_ticks = '0; run_valid = 1'b0; run_slot = 0; switch_cnt = '0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_valid[i] = 1'b0; slot_dur[i] = '0; slot_per[i] = '0; slot_dl[i] = '0;
      slot_next[i] = '0; job_on[i] = 1'b0; job_rel[i] = '0; job_ran[i] = '0;
      lost_cnt[i] = '0; turn_sum[i] = '0; wait_acc[i] = '0; inst_cnt[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_mode(1'b0);

    // directed: extremes, zero period, deadline above period, reload, unused type
    add_req(mk_req(REQ_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    add_req(mk_req(REQ_LOAD, 3'd0, 16'd0, 16'd2, 16'd0, 16'd5));
    add_req(mk_req(REQ_LOAD, 3'd7, 16'd1, 16'hFFFF, 16'd4, 16'hFFFF));
    add_req(mk_req(REQ_LOAD, 3'd3, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1));
    add_req(mk_req(REQ_LOAD, 3'd1, 16'd0, 16'd0, 16'd3, 16'd3));
    repeat (6) add_req(mk_req(REQ_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_req(mk_req(REQ_LOAD, 3'd7, 16'd0, 16'd1, 16'd2, 16'd1));
    add_req(mk_req(REQ_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    add_req(mk_req(REQ_TICK, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    add_req(mk_req(REQ_SPARE, 3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_req(mk_req(REQ_READ, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    add_req(mk_req(REQ_READ, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_req(mk_req(REQ_READ, 3'd1, 16'd0, 16'd0, 16'd0, 16'd0));
    drain();

    // random phases across both modes
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0] ? 1'b0 : 1'b1);
      for (int n = 0; n < 160; n++) add_req(rnd_req());
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
